/* src/imuar_pkg.sv */
`timescale 1ns / 1ps

package imuar_pkg;

	// Fixed field widths of the sample and result channels.
	localparam int FIELD_W = 16;
	localparam int OUT_W = 17;
	localparam int CFG_W = 6;
	localparam int AXES = 6;
	localparam int WIN_RESET = 20;

	// Shared multiplier: signed operands and product.
	localparam int MUL_W = 18;
	localparam int PROD_W = 36;
	// Quaternion products, matrix entries (times |q|^2) and averages.
	localparam int QPROD = 10;
	localparam int QP_W = 32;
	localparam int MAT_W = 34;
	localparam int MAT_N = 9;
	localparam int AVG_W = 17;
	// Lower slice of a matrix entry fed to the multiplier in the first half.
	localparam int MLO_W = 17;

	// Shared divider: numerator magnitude, divisor and iteration count.
	localparam int NUM_W = 54;
	localparam int DEN_W = 34;
	localparam int AVG_DIV_BITS = 26;
	localparam int CNT_W = 6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_AVG,
		ST_AVG_WAIT,
		ST_QMUL,
		ST_QCAP,
		ST_MAT,
		ST_RMUL,
		ST_RACC,
		ST_RDIV,
		ST_RWAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic short_op;
		logic [NUM_W-1:0] mag;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	// Applies the sign to a rounded quotient magnitude and clamps it to the result range.
	function automatic logic signed [OUT_W-1:0] sat_out(input logic neg,
			input logic [NUM_W-1:0] mag);
		logic signed [OUT_W-1:0] r;
		if (neg) begin
			if (mag > NUM_W'(65536)) begin
				r = -OUT_W'(65536);
			end else begin
				r = -$signed(OUT_W'(mag));
			end
		end else begin
			if (mag > NUM_W'(65535)) begin
				r = OUT_W'(65535);
			end else begin
				r = $signed(OUT_W'(mag));
			end
		end
		return r;
	endfunction

endpackage

/* src/imu_average_and_rotate_core.sv */
`timescale 1ns / 1ps

// IMU moving average and quaternion rotation.
// A request on the input channel carries a quaternion (Q1.14) and raw
// acceleration and angular-rate vectors; it is accepted when in_valid is
// high and in_stall is low. Each axis is averaged over the last window_len
// samples, and both averages are rotated into the global frame.
// One result leaves on the output channel per request, held in an output
// register until out_valid is high and out_stall is low; a new request may
// be accepted while that result still waits.
// The block does not take the next request until the result is in the output
// register. The shared divider, which yields one quotient bit per cycle, runs
// over 26 numerator bits for each of the six averages and over 54 for each of
// the six rotated outputs; the shared multiplier forms the ten quaternion
// products and six partial products per rotated output. A zero quaternion
// skips the rotation. in_stall stays high for the whole computation, and if
// the previous result is still stalled the block holds in its final state.
// A write of cfg_wr_en sets the window length (0 acts as 1) and clears the
// history, the sums and the write position. Reset sets the window to 20 and
// clears the same state; the history rows are cleared through valid bits.
module imu_average_and_rotate_core #(
	parameter int WINDOW_MAX = 32,
	parameter int SAMPLE_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_wr_en,
	input logic [imuar_pkg::CFG_W-1:0] cfg_wr_data,
	input logic in_valid,
	output logic in_stall,
	input logic signed [imuar_pkg::FIELD_W-1:0] quat_x,
	input logic signed [imuar_pkg::FIELD_W-1:0] quat_y,
	input logic signed [imuar_pkg::FIELD_W-1:0] quat_z,
	input logic signed [imuar_pkg::FIELD_W-1:0] quat_w,
	input logic signed [imuar_pkg::FIELD_W-1:0] accel_x,
	input logic signed [imuar_pkg::FIELD_W-1:0] accel_y,
	input logic signed [imuar_pkg::FIELD_W-1:0] accel_z,
	input logic signed [imuar_pkg::FIELD_W-1:0] gyro_x,
	input logic signed [imuar_pkg::FIELD_W-1:0] gyro_y,
	input logic signed [imuar_pkg::FIELD_W-1:0] gyro_z,
	output logic out_valid,
	input logic out_stall,
	output logic signed [imuar_pkg::OUT_W-1:0] accel_out_x,
	output logic signed [imuar_pkg::OUT_W-1:0] accel_out_y,
	output logic signed [imuar_pkg::OUT_W-1:0] accel_out_z,
	output logic signed [imuar_pkg::OUT_W-1:0] gyro_out_x,
	output logic signed [imuar_pkg::OUT_W-1:0] gyro_out_y,
	output logic signed [imuar_pkg::OUT_W-1:0] gyro_out_z,
	output logic quat_error
);
	import imuar_pkg::*;

	localparam int SB = (SAMPLE_BITS > FIELD_W) ? FIELD_W : SAMPLE_BITS;
	localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SW = SB + $clog2(WINDOW_MAX) + 1;
	localparam int CW = (PW + 1 > CFG_W + 1) ? PW + 1 : CFG_W + 1;
	localparam int HW = AXES * SB;
	localparam logic [CFG_W-1:0] WIN_INIT =
		CFG_W'((WIN_RESET > WINDOW_MAX) ? WINDOW_MAX : WIN_RESET);

	state_t state_q, state_d;

	logic [CFG_W-1:0] win_q;
	logic [CFG_W-1:0] win_sat;
	logic [PW-1:0] pos_q;
	logic [CW-1:0] pos_inc;
	logic signed [SW-1:0] sum_q [AXES];
	logic [2:0] axis_q;
	logic [3:0] k_q;
	logic [2:0] term_q;
	logic out_valid_q;

	logic signed [FIELD_W-1:0] quat_q [4];
	logic signed [SB-1:0] samp_q [AXES];
	logic signed [AVG_W-1:0] avg_q [AXES];
	logic signed [QP_W-1:0] prod_q [QPROD];
	logic signed [MAT_W-1:0] m_q [MAT_N];
	logic signed [MAT_W-1:0] d_q;
	logic signed [NUM_W-1:0] acc_q;
	logic signed [OUT_W-1:0] res_q [AXES];
	logic qerr_q;
	logic neg_q;

	logic hist_rd;
	logic hist_wr;
	logic [HW-1:0] hist_wdata;
	logic [HW-1:0] hist_rdata;

	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [1:0] row;
	logic [1:0] col;
	logic [2:0] avg_idx;
	logic [3:0] m_idx;
	logic signed [MAT_W-1:0] m_sel;
	logic signed [NUM_W-1:0] sum_ext;
	logic [NUM_W-1:0] sum_mag;
	logic [NUM_W-1:0] acc_mag;
	logic signed [NUM_W-1:0] prod_ext;
	logic signed [MAT_W-1:0] pe [QPROD];
	logic signed [MAT_W-1:0] d_new;
	logic out_load;

	imuar_hist #(
		.DEPTH(WINDOW_MAX),
		.AW(PW),
		.DW(HW)
	) u_hist (
		.clk(clk),
		.arst_n(arst_n),
		.clr(cfg_wr_en),
		.rd_en(hist_rd),
		.wr_en(hist_wr),
		.addr(pos_q),
		.wdata(hist_wdata),
		.rdata(hist_rdata)
	);

	imuar_mul u_mul (
		.clk(clk),
		.a(mul_a),
		.b(mul_b),
		.p(mul_p)
	);

	imuar_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	// Window length as written, with zero taken as one and capped at the depth.
	always_comb begin
		if (cfg_wr_data == '0) begin
			win_sat = CFG_W'(1);
		end else if (32'(cfg_wr_data) > 32'(WINDOW_MAX)) begin
			win_sat = CFG_W'(WINDOW_MAX);
		end else begin
			win_sat = cfg_wr_data;
		end
		pos_inc = CW'(pos_q) + CW'(1);
	end

	// New history row made of the captured samples.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			hist_wdata[a*SB +: SB] = samp_q[a];
		end
	end

	// Operand selection for the rotation: output row, matrix column and half.
	always_comb begin
		row = (axis_q < 3'd3) ? axis_q[1:0] : 2'(axis_q - 3'd3);
		col = term_q[2:1];
		avg_idx = ((axis_q < 3'd3) ? 3'd0 : 3'd3) + 3'(col);
		m_idx = 4'(row) * 4'd3 + 4'(col);
		m_sel = m_q[m_idx];
		sum_ext = NUM_W'(sum_q[axis_q]);
		sum_mag = (sum_ext < 0) ? NUM_W'(-sum_ext) : NUM_W'(sum_ext);
		acc_mag = (acc_q < 0) ? NUM_W'(-acc_q) : NUM_W'(acc_q);
		prod_ext = NUM_W'(mul_p);
	end

	// Shared multiplier operands.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_QMUL: begin
				case (k_q)
					4'd0: begin mul_a = MUL_W'(quat_q[0]); mul_b = MUL_W'(quat_q[0]); end
					4'd1: begin mul_a = MUL_W'(quat_q[1]); mul_b = MUL_W'(quat_q[1]); end
					4'd2: begin mul_a = MUL_W'(quat_q[2]); mul_b = MUL_W'(quat_q[2]); end
					4'd3: begin mul_a = MUL_W'(quat_q[3]); mul_b = MUL_W'(quat_q[3]); end
					4'd4: begin mul_a = MUL_W'(quat_q[0]); mul_b = MUL_W'(quat_q[1]); end
					4'd5: begin mul_a = MUL_W'(quat_q[3]); mul_b = MUL_W'(quat_q[2]); end
					4'd6: begin mul_a = MUL_W'(quat_q[0]); mul_b = MUL_W'(quat_q[2]); end
					4'd7: begin mul_a = MUL_W'(quat_q[3]); mul_b = MUL_W'(quat_q[1]); end
					4'd8: begin mul_a = MUL_W'(quat_q[1]); mul_b = MUL_W'(quat_q[2]); end
					4'd9: begin mul_a = MUL_W'(quat_q[3]); mul_b = MUL_W'(quat_q[0]); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			ST_RMUL: begin
				mul_a = MUL_W'(avg_q[avg_idx]);
				if (term_q[0]) begin
					mul_b = MUL_W'($signed(m_sel[MAT_W-1:MLO_W]));
				end else begin
					mul_b = $signed({1'b0, m_sel[MLO_W-1:0]});
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Divider requests: rounded averages and rounded rotated outputs.
	always_comb begin
		div_req = '0;
		case (state_q)
			ST_AVG: begin
				div_req.start = 1'b1;
				div_req.short_op = 1'b1;
				div_req.mag = sum_mag + NUM_W'(win_q >> 1);
				div_req.den = DEN_W'(win_q);
			end
			ST_RDIV: begin
				div_req.start = 1'b1;
				div_req.short_op = 1'b0;
				div_req.mag = acc_mag + NUM_W'(d_q >>> 1);
				div_req.den = DEN_W'(d_q);
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	// Quaternion products widened to matrix width, and the squared norm.
	always_comb begin
		for (int k = 0; k < QPROD; k++) begin
			pe[k] = MAT_W'(prod_q[k]);
		end
		d_new = pe[0] + pe[1] + pe[2] + pe[3];
	end

	// Sequencer next state and handshake outputs.
	always_comb begin
		state_d = state_q;
		hist_rd = 1'b0;
		hist_wr = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				hist_rd = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				hist_wr = 1'b1;
				state_d = ST_AVG;
			end
			ST_AVG: begin
				state_d = ST_AVG_WAIT;
			end
			ST_AVG_WAIT: begin
				if (div_rsp.done) begin
					state_d = (axis_q == 3'(AXES - 1)) ? ST_QMUL : ST_AVG;
				end
			end
			ST_QMUL: begin
				state_d = ST_QCAP;
			end
			ST_QCAP: begin
				state_d = (k_q == 4'(QPROD - 1)) ? ST_MAT : ST_QMUL;
			end
			ST_MAT: begin
				state_d = (d_new == '0) ? ST_DONE : ST_RMUL;
			end
			ST_RMUL: begin
				state_d = ST_RACC;
			end
			ST_RACC: begin
				state_d = (term_q == 3'd5) ? ST_RDIV : ST_RMUL;
			end
			ST_RDIV: begin
				state_d = ST_RWAIT;
			end
			ST_RWAIT: begin
				if (div_rsp.done) begin
					state_d = (axis_q == 3'(AXES - 1)) ? ST_DONE : ST_RMUL;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: window, position, running sums, counters and result flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= WIN_INIT;
			pos_q <= '0;
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= '0;
			end
			axis_q <= '0;
			k_q <= '0;
			term_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				win_q <= win_sat;
				pos_q <= '0;
				for (int a = 0; a < AXES; a++) begin
					sum_q[a] <= '0;
				end
			end else if (state_q == ST_SUM) begin
				for (int a = 0; a < AXES; a++) begin
					sum_q[a] <= sum_q[a] + SW'(samp_q[a])
						- SW'($signed(hist_rdata[a*SB +: SB]));
				end
				pos_q <= (pos_inc >= CW'(win_q)) ? '0 : PW'(pos_inc);
			end
			case (state_q)
				ST_SUM: begin
					axis_q <= '0;
				end
				ST_AVG_WAIT: begin
					if (div_rsp.done) begin
						axis_q <= (axis_q == 3'(AXES - 1)) ? 3'd0 : axis_q + 3'd1;
						k_q <= '0;
					end
				end
				ST_QCAP: begin
					k_q <= k_q + 4'd1;
				end
				ST_MAT: begin
					axis_q <= '0;
					term_q <= '0;
				end
				ST_RACC: begin
					term_q <= (term_q == 3'd5) ? 3'd0 : term_q + 3'd1;
				end
				ST_RWAIT: begin
					if (div_rsp.done) begin
						axis_q <= axis_q + 3'd1;
					end
				end
				default: begin
					axis_q <= axis_q;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					quat_q[0] <= quat_x;
					quat_q[1] <= quat_y;
					quat_q[2] <= quat_z;
					quat_q[3] <= quat_w;
					samp_q[0] <= $signed(accel_x[SB-1:0]);
					samp_q[1] <= $signed(accel_y[SB-1:0]);
					samp_q[2] <= $signed(accel_z[SB-1:0]);
					samp_q[3] <= $signed(gyro_x[SB-1:0]);
					samp_q[4] <= $signed(gyro_y[SB-1:0]);
					samp_q[5] <= $signed(gyro_z[SB-1:0]);
				end
			end
			ST_AVG: begin
				neg_q <= (sum_ext < 0);
			end
			ST_AVG_WAIT: begin
				if (div_rsp.done) begin
					avg_q[axis_q] <= neg_q ? -$signed(AVG_W'(div_rsp.quo))
						: $signed(AVG_W'(div_rsp.quo));
				end
			end
			ST_QCAP: begin
				prod_q[k_q] <= QP_W'(mul_p);
			end
			ST_MAT: begin
				d_q <= d_new;
				qerr_q <= (d_new == '0);
				acc_q <= '0;
				m_q[0] <= d_new - ((pe[1] + pe[2]) <<< 1);
				m_q[1] <= (pe[4] - pe[5]) <<< 1;
				m_q[2] <= (pe[6] + pe[7]) <<< 1;
				m_q[3] <= (pe[4] + pe[5]) <<< 1;
				m_q[4] <= d_new - ((pe[0] + pe[2]) <<< 1);
				m_q[5] <= (pe[8] - pe[9]) <<< 1;
				m_q[6] <= (pe[6] - pe[7]) <<< 1;
				m_q[7] <= (pe[8] + pe[9]) <<< 1;
				m_q[8] <= d_new - ((pe[0] + pe[1]) <<< 1);
			end
			ST_RACC: begin
				acc_q <= acc_q + (term_q[0] ? (prod_ext <<< MLO_W) : prod_ext);
			end
			ST_RDIV: begin
				neg_q <= (acc_q < 0);
			end
			ST_RWAIT: begin
				if (div_rsp.done) begin
					res_q[axis_q] <= sat_out(neg_q, div_rsp.quo);
					acc_q <= '0;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					accel_out_x <= qerr_q ? avg_q[0] : res_q[0];
					accel_out_y <= qerr_q ? avg_q[1] : res_q[1];
					accel_out_z <= qerr_q ? avg_q[2] : res_q[2];
					gyro_out_x <= qerr_q ? avg_q[3] : res_q[3];
					gyro_out_y <= qerr_q ? avg_q[4] : res_q[4];
					gyro_out_z <= qerr_q ? avg_q[5] : res_q[5];
					quat_error <= qerr_q;
				end
			end
			default: begin
				neg_q <= neg_q;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// An accepted request keeps the block busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("block took a request without going busy");

	// The divider only runs while the sequencer waits for it.
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> (state_q == ST_AVG_WAIT || state_q == ST_RWAIT))
		else $error("divider running outside a wait state");

	// With a zero quaternion the outputs are plain averages of 16-bit samples; accel_out_x is checked against that range.
	a_qerr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && quat_error) |->
		(accel_out_x >= -$signed(OUT_W'(32768)) && accel_out_x <= $signed(OUT_W'(32767))))
		else $error("unrotated average out of sample range");
`endif

endmodule

/* src/imuar_mul.sv */
`timescale 1ns / 1ps

module imuar_mul (
	input logic clk,
	input logic signed [imuar_pkg::MUL_W-1:0] a,
	input logic signed [imuar_pkg::MUL_W-1:0] b,
	output logic signed [imuar_pkg::PROD_W-1:0] p
);
	import imuar_pkg::*;

	// Registered signed product, ready the cycle after the operands.
	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

/* src/imuar_div.sv */
`timescale 1ns / 1ps

module imuar_div (
	input logic clk,
	input logic arst_n,
	input imuar_pkg::div_req_t req,
	output imuar_pkg::div_rsp_t rsp
);
	import imuar_pkg::*;

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DEN_W:0] shifted;
	logic [DEN_W:0] diff;
	logic ge;

	// One restoring step: bring down the next numerator bit and try to subtract.
	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		diff = shifted - {1'b0, den_q};
		ge = ~diff[DEN_W];
	end

	// Iteration control; a short request only runs over the low numerator bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.short_op ? CNT_W'(AVG_DIV_BITS) : CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.short_op ? (req.mag << (NUM_W - AVG_DIV_BITS)) : req.mag;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

endmodule

/* src/imuar_hist.sv */
`timescale 1ns / 1ps

module imuar_hist #(
	parameter int DEPTH = 32,
	parameter int AW = 5,
	parameter int DW = 96
) (
	input logic clk,
	input logic arst_n,
	input logic clr,
	input logic rd_en,
	input logic wr_en,
	input logic [AW-1:0] addr,
	input logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);
	import imuar_pkg::*;

	logic [DW-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [DW-1:0] rd_q;
	logic rd_valid_q;

	// Row valid bits; a row never written since clearing reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_valid_q <= valid_q[addr];
			end
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[addr] <= 1'b1;
			end
		end
	end

	// Sample rows, one per window position, with a registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem[addr];
		end
	end

	assign rdata = rd_valid_q ? rd_q : '0;

endmodule

/* dv/tb_imu_average_and_rotate_core.sv */
`timescale 1ns / 1ps

module tb_imu_average_and_rotate_core;
	import imuar_pkg::*;

	// Sample fields packed as {qx, qy, qz, qw, ax, ay, az, gx, gy, gz}.
	typedef logic [9:0][FIELD_W-1:0] sample_t;
	// Result fields packed as {ax, ay, az, gx, gy, gz} followed by the error flag.
	typedef struct packed {
		logic [5:0][OUT_W-1:0] vec;
		logic qerr;
	} frame_t;

	typedef struct packed {
		logic do_cfg;
		logic [CFG_W-1:0] cfg;
		sample_t smp;
		logic typed;
		frame_t want;
	} row_t;

	localparam int WMAX = 32;
	localparam int SETTLE = 20;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;
	logic in_valid;
	logic in_stall;
	logic signed [FIELD_W-1:0] quat_x, quat_y, quat_z, quat_w;
	logic signed [FIELD_W-1:0] accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z;
	logic out_valid;
	logic out_stall;
	logic signed [OUT_W-1:0] accel_out_x, accel_out_y, accel_out_z;
	logic signed [OUT_W-1:0] gyro_out_x, gyro_out_y, gyro_out_z;
	logic quat_error;

	imu_average_and_rotate_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.quat_x(quat_x),
		.quat_y(quat_y),
		.quat_z(quat_z),
		.quat_w(quat_w),
		.accel_x(accel_x),
		.accel_y(accel_y),
		.accel_z(accel_z),
		.gyro_x(gyro_x),
		.gyro_y(gyro_y),
		.gyro_z(gyro_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accel_out_x(accel_out_x),
		.accel_out_y(accel_out_y),
		.accel_out_z(accel_out_z),
		.gyro_out_x(gyro_out_x),
		.gyro_out_y(gyro_out_y),
		.gyro_out_z(gyro_out_z),
		.quat_error(quat_error)
	);

	// Shadow copy of the averaging state and window length.
	longint hist [AXES][WMAX];
	longint axis_sum [AXES];
	int wr_pos;
	int win_len;

	frame_t pending_frames[$];
	row_t stim_rows[$];
	int n_errors;
	int n_requests;
	int n_results;
	int n_zero_quat;

	function automatic void clear_window_state();
		for (int a = 0; a < AXES; a++) begin
			axis_sum[a] = 0;
			for (int k = 0; k < WMAX; k++) begin
				hist[a][k] = 0;
			end
		end
		wr_pos = 0;
	endfunction

	function automatic longint round_div(longint num, longint den);
		if (num >= 0) begin
			return (num + den / 2) / den;
		end
		return -((-num + den / 2) / den);
	endfunction

	function automatic logic [OUT_W-1:0] clamp_out(longint v);
		if (v > 65535) begin
			v = 65535;
		end else if (v < -65536) begin
			v = -65536;
		end
		return OUT_W'(v);
	endfunction

	// Updates the moving averages with one sample and returns the rotated result (the averages for a zero quaternion).
	function automatic frame_t average_and_rotate(sample_t s);
		longint avg [AXES];
		longint res [AXES];
		longint m [3][3];
		longint x, y, z, w, d, smp, num;
		int pos;
		frame_t f;
		pos = (wr_pos >= win_len) ? 0 : wr_pos;
		for (int a = 0; a < AXES; a++) begin
			smp = longint'($signed(s[5 - a]));
			axis_sum[a] += smp - hist[a][pos];
			hist[a][pos] = smp;
			avg[a] = round_div(axis_sum[a], win_len);
		end
		pos++;
		wr_pos = (pos >= win_len) ? 0 : pos;
		x = longint'($signed(s[9]));
		y = longint'($signed(s[8]));
		z = longint'($signed(s[7]));
		w = longint'($signed(s[6]));
		d = x * x + y * y + z * z + w * w;
		f.qerr = (d == 0);
		if (f.qerr) begin
			res = avg;
		end else begin
			m[0][0] = d - 2 * (y * y + z * z);
			m[0][1] = 2 * (x * y - w * z);
			m[0][2] = 2 * (x * z + w * y);
			m[1][0] = 2 * (x * y + w * z);
			m[1][1] = d - 2 * (x * x + z * z);
			m[1][2] = 2 * (y * z - w * x);
			m[2][0] = 2 * (x * z - w * y);
			m[2][1] = 2 * (y * z + w * x);
			m[2][2] = d - 2 * (x * x + y * y);
			for (int v = 0; v < 2; v++) begin
				for (int i = 0; i < 3; i++) begin
					num = avg[v * 3] * m[i][0] + avg[v * 3 + 1] * m[i][1]
						+ avg[v * 3 + 2] * m[i][2];
					res[v * 3 + i] = round_div(num, d);
				end
			end
		end
		for (int a = 0; a < AXES; a++) begin
			f.vec[5 - a] = clamp_out(res[a]);
		end
		return f;
	endfunction

	function automatic row_t mk_row(logic do_cfg, int cfg, sample_t smp, logic typed,
			logic [5:0][OUT_W-1:0] vec, logic qerr);
		row_t r;
		r.do_cfg = do_cfg;
		r.cfg = CFG_W'(cfg);
		r.smp = smp;
		r.typed = typed;
		r.want.vec = vec;
		r.want.qerr = qerr;
		return r;
	endfunction

	function automatic logic [FIELD_W-1:0] rand_field();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return FIELD_W'($urandom_range(0, 64) - 32);
			default: return FIELD_W'($urandom);
		endcase
	endfunction

	// Mostly well-formed orientations, with zero and degenerate quaternions mixed in.
	function automatic sample_t rand_sample();
		sample_t s;
		int mode;
		mode = $urandom_range(0, 15);
		for (int k = 0; k < 6; k++) begin
			s[k] = rand_field();
		end
		for (int k = 6; k < 10; k++) begin
			case (mode)
				0: s[k] = '0;
				1, 2: s[k] = FIELD_W'($urandom_range(0, 6) - 3);
				3: s[k] = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
				default: s[k] = FIELD_W'($urandom);
			endcase
		end
		return s;
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// Waits until every expected result has come and the block has settled.
	task automatic drain();
		while (pending_frames.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_window(int val);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= CFG_W'(val);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		win_len = (val == 0) ? 1 : ((val > WMAX) ? WMAX : val);
		clear_window_state();
	endtask

	// Presents one request and holds it until the block takes it.
	task automatic send_sample(sample_t s, logic typed, frame_t want);
		frame_t pred;
		in_valid <= 1'b1;
		{quat_x, quat_y, quat_z, quat_w, accel_x, accel_y, accel_z,
			gyro_x, gyro_y, gyro_z} <= s;
		do begin
			@(posedge clk);
		end while (in_stall);
		pred = average_and_rotate(s);
		pending_frames.push_back(typed ? want : pred);
		n_requests++;
		if (pred.qerr) begin
			n_zero_quat++;
		end
	endtask

	// Sender gaps come in bursts: after each burst the valid line drops for a while.
	int burst_left;
	task automatic sender_gap();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			burst_left = $urandom_range(0, 8);
		end
	endtask

	// Main stimulus.
	initial begin
		int phase_win [10];
		frame_t dummy;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		{quat_x, quat_y, quat_z, quat_w, accel_x, accel_y, accel_z,
			gyro_x, gyro_y, gyro_z} = '0;
		n_errors = 0;
		n_requests = 0;
		n_results = 0;
		n_zero_quat = 0;
		burst_left = 0;
		dummy = '0;
		win_len = WIN_RESET;
		clear_window_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight after reset, with the default window.
		stim_rows.push_back(mk_row(0, 0, '0, 1, '0, 1));
		stim_rows.push_back(mk_row(0, 0, {48'd0, 16'sd16384, 96'd0}, 1, '0, 0));
		stim_rows.push_back(mk_row(0, 0, {64'd0, {6{16'h7FFF}}}, 0, '0, 0));
		stim_rows.push_back(mk_row(0, 0, {16'sd1000, -16'sd2000, 16'sd3000, 16'sd16000,
			16'sd100, -16'sd200, 16'sd300, -16'sd32768, 16'sd32767, 16'sd5}, 0, '0, 0));
		// Window of one: the identity and half turns about each axis give exact results.
		stim_rows.push_back(mk_row(1, 1, {48'd0, 16'sd16384, 16'sd32767, -16'sd32768,
			16'sd1, -16'sd1, 16'sd0, 16'sd100}, 1, {17'sd32767, -17'sd32768, 17'sd1,
			-17'sd1, 17'sd0, 17'sd100}, 0));
		stim_rows.push_back(mk_row(0, 0, {16'sd16384, 48'd0, {3{16'h8000}},
			{3{16'h7FFF}}}, 1, {-17'sd32768, 17'sd32768, 17'sd32768, 17'sd32767,
			-17'sd32767, -17'sd32767}, 0));
		stim_rows.push_back(mk_row(0, 0, {16'sd0, 16'sd16384, 32'd0, 16'sd100, 16'sd200,
			16'sd300, 48'd0}, 1, {-17'sd100, 17'sd200, -17'sd300, 51'd0}, 0));
		stim_rows.push_back(mk_row(0, 0, {32'd0, -16'sd16384, 16'sd0, 48'd0, 16'sd5,
			16'sd6, 16'sd7}, 1, {51'd0, -17'sd5, -17'sd6, 17'sd7}, 0));
		stim_rows.push_back(mk_row(0, 0, {64'd0, 16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sd5,
			16'sd6}, 1, {17'sd1, 17'sd2, 17'sd3, 17'sd4, 17'sd5, 17'sd6}, 1));
		stim_rows.push_back(mk_row(0, 0, {{4{16'h8000}}, {6{16'h7FFF}}}, 0, '0, 0));
		stim_rows.push_back(mk_row(0, 0, {{4{16'h7FFF}}, {6{16'h8000}}}, 0, '0, 0));
		stim_rows.push_back(mk_row(0, 0, {16'sd1, 48'd0, 16'sd1234, -16'sd4321,
			16'sd77, 16'sd9, -16'sd9, 16'sd0}, 0, '0, 0));
		// A zero length acts as one; an oversize one is held at the maximum.
		stim_rows.push_back(mk_row(1, 0, {48'd0, 16'sd16384, 16'sd7, -16'sd7, 16'sd3,
			16'sd2, 16'sd1, 16'sd0}, 0, '0, 0));
		stim_rows.push_back(mk_row(1, 63, {16'sd300, 16'sd400, 16'sd500, 16'sd600,
			{6{16'h7FFF}}}, 0, '0, 0));
		stim_rows.push_back(mk_row(0, 0, {16'sd300, 16'sd400, 16'sd500, 16'sd600,
			{6{16'h8000}}}, 0, '0, 0));
		stim_rows.push_back(mk_row(0, 0, {16'sd3, 16'sd0, 16'sd0, 16'sd0,
			16'sd1, 16'sd1, 16'sd1, -16'sd1, -16'sd1, -16'sd1}, 0, '0, 0));
		foreach (stim_rows[i]) begin
			if (stim_rows[i].do_cfg) begin
				in_valid <= 1'b0;
				burst_left = 0;
				write_window(stim_rows[i].cfg);
			end
			send_sample(stim_rows[i].smp, stim_rows[i].typed, stim_rows[i].want);
			sender_gap();
		end

		// Random part over a series of window lengths, the extremes among them.
		phase_win = '{2, 32, 20, 5, 1, 17, 31, 0, 63, $urandom_range(1, 32)};
		for (int p = 0; p < 10; p++) begin
			in_valid <= 1'b0;
			burst_left = 0;
			write_window(phase_win[p]);
			for (int i = 0; i < 150; i++) begin
				send_sample(rand_sample(), 1'b0, dummy);
				if (p == 4 && i == 75) begin
					// Let the pipeline empty completely before carrying on.
					in_valid <= 1'b0;
					burst_left = 0;
					drain();
				end else begin
					sender_gap();
				end
			end
		end
		in_valid <= 1'b0;
		drain();

		$display("Checked %0d results from %0d requests over 14 window settings.",
			n_results, n_requests);
		$display("Of these, %0d requests carried a zero quaternion.", n_zero_quat);
		if (n_errors == 0 && pending_frames.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Receiver stall pattern: calm stretches, light stalling and heavy stalling.
	int stall_mode;
	int stall_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= 0;
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt % 300 == 0) begin
				stall_mode <= $urandom_range(0, 2);
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Compare each accepted result with the oldest expectation.
	frame_t got;
	frame_t exp_frame;
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got.vec = {accel_out_x, accel_out_y, accel_out_z,
				gyro_out_x, gyro_out_y, gyro_out_z};
			got.qerr = quat_error;
			n_results++;
			if (pending_frames.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				n_errors++;
			end else begin
				exp_frame = pending_frames.pop_front();
				for (int k = 5; k >= 0; k--) begin
					if (got.vec[k] !== exp_frame.vec[k]) begin
						$display("%0t: output field %0d expected %0d, actual %0d", $time,
							5 - k, $signed(exp_frame.vec[k]), $signed(got.vec[k]));
						n_errors++;
					end
				end
				if (got.qerr !== exp_frame.qerr) begin
					$display("%0t: quat_error expected %b, actual %b", $time,
						exp_frame.qerr, got.qerr);
					n_errors++;
				end
			end
		end
	end

	// Watchdog.
	initial begin
		#60_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
